// ===== rtl/core/tpfa_pkg.sv =====
// shared types, codes and constants of the tabulated pair force accumulator
package tpfa_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int SITE_COUNT  = 256;
	localparam int TAB_AW      = $clog2(TABLE_DEPTH);
	localparam int SITE_AW     = $clog2(SITE_COUNT);
	localparam int ACC_W       = 48;
	localparam int PTS_W       = 11;
	localparam logic [15:0] HALF_Q16 = 16'h8000;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_EVAL  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	typedef struct packed {
		logic       load;
		logic       tab_we;
		logic       clr_we;
		logic       mim_init;
		logic       mim_step;
		logic       mim_fin;
		logic       sq_mul;
		logic       sq_acc;
		logic [1:0] mul_lane;
		logic [1:0] acc_lane;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       pos_hi;
		logic       pos_lo;
		logic       pos_calc;
		logic       sel_calc;
		logic       tab_rd;
		logic       tab_rd_next;
		logic       f0_cap;
		logic       imul;
		logic       fcalc;
		logic       g_mul;
		logic       g_cap;
		logic       gdiv_step;
		logic       site_rd;
		logic       site_b;
		logic       site_add;
		logic       site_sub;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic mim_on;
		logic interp;
		logic noupd;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/tpfa_ctrl.sv =====
// sequencer of the tabulated pair force accumulator
module tpfa_ctrl import tpfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_action,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [5:0] MIM_LAST  = 6'd33;
	localparam logic [5:0] ROOT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST  = 6'd31;
	localparam logic [5:0] LANE_LAST = 6'd3;

	typedef enum logic [24:0] {
		S_IDLE = 25'h0000001,
		S_TWR  = 25'h0000002,
		S_CLR  = 25'h0000004,
		S_MINI = 25'h0000008,
		S_MSTP = 25'h0000010,
		S_MFIN = 25'h0000020,
		S_SQ   = 25'h0000040,
		S_SQI  = 25'h0000080,
		S_SQRT = 25'h0000100,
		S_PHI  = 25'h0000200,
		S_PLO  = 25'h0000400,
		S_PCAL = 25'h0000800,
		S_SEL  = 25'h0001000,
		S_TR0  = 25'h0002000,
		S_TR1  = 25'h0004000,
		S_IMUL = 25'h0008000,
		S_FCAL = 25'h0010000,
		S_GMUL = 25'h0020000,
		S_GDIV = 25'h0040000,
		S_RA   = 25'h0080000,
		S_WA   = 25'h0100000,
		S_RB   = 25'h0200000,
		S_WB   = 25'h0400000,
		S_RO   = 25'h0800000,
		S_RL   = 25'h1000000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cnt_d        = cnt_q + 6'd1;
		in_ready     = 1'b0;
		cmd.mul_lane = cnt_q[1:0];
		cmd.acc_lane = cnt_q[1:0] - 2'd1;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_action)
						ACT_WRITE: state_d = S_TWR;
						ACT_EVAL:  state_d = sts.mim_on ? S_MINI : S_SQ;
						ACT_READ:  state_d = S_RO;
						default:   state_d = S_CLR;
					endcase
				end
			end
			S_TWR: begin
				cmd.tab_we = 1'b1;
				state_d    = S_RO;
			end
			S_CLR: begin
				cmd.clr_we = 1'b1;
				state_d    = S_RO;
			end
			S_MINI: begin
				cmd.mim_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_MSTP;
			end
			S_MSTP: begin
				cmd.mim_step = 1'b1;
				if (cnt_q == MIM_LAST) state_d = S_MFIN;
			end
			S_MFIN: begin
				cmd.mim_fin = 1'b1;
				cnt_d       = '0;
				state_d     = S_SQ;
			end
			S_SQ: begin
				cmd.sq_mul = (cnt_q != LANE_LAST);
				cmd.sq_acc = (cnt_q != 6'd0);
				if (cnt_q == LANE_LAST) state_d = S_SQI;
			end
			S_SQI: begin
				cmd.sqrt_init = 1'b1;
				cnt_d         = '0;
				state_d       = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == ROOT_LAST) state_d = S_PHI;
			end
			S_PHI: begin
				cmd.pos_hi = 1'b1;
				state_d    = S_PLO;
			end
			S_PLO: begin
				cmd.pos_lo = 1'b1;
				state_d    = S_PCAL;
			end
			S_PCAL: begin
				cmd.pos_calc = 1'b1;
				state_d      = S_SEL;
			end
			S_SEL: begin
				cmd.sel_calc = 1'b1;
				state_d      = S_TR0;
			end
			S_TR0: begin
				cmd.tab_rd = 1'b1;
				state_d    = sts.noupd ? S_RO : S_TR1;
			end
			S_TR1: begin
				cmd.tab_rd_next = 1'b1;
				cmd.f0_cap      = 1'b1;
				state_d         = sts.interp ? S_IMUL : S_FCAL;
			end
			S_IMUL: begin
				cmd.imul = 1'b1;
				state_d  = S_FCAL;
			end
			S_FCAL: begin
				cmd.fcalc = 1'b1;
				cnt_d     = '0;
				state_d   = S_GMUL;
			end
			S_GMUL: begin
				cmd.g_mul = (cnt_q != LANE_LAST);
				cmd.g_cap = (cnt_q != 6'd0);
				if (cnt_q == LANE_LAST) begin
					cnt_d   = '0;
					state_d = S_GDIV;
				end
			end
			S_GDIV: begin
				cmd.gdiv_step = 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_RA;
			end
			S_RA: begin
				cmd.site_rd = 1'b1;
				state_d     = S_WA;
			end
			S_WA: begin
				cmd.site_add = 1'b1;
				state_d      = S_RB;
			end
			S_RB: begin
				cmd.site_rd = 1'b1;
				cmd.site_b  = 1'b1;
				state_d     = S_WB;
			end
			S_WB: begin
				cmd.site_sub = 1'b1;
				cmd.site_b   = 1'b1;
				state_d      = S_RO;
			end
			S_RO: begin
				cmd.site_rd = 1'b1;
				state_d     = S_RL;
			end
			S_RL: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/tpfa_dp.sv =====
// datapath: registers, table and accumulator memories, iterative arithmetic
module tpfa_dp import tpfa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic [1:0]               in_action,
	input  logic [SITE_AW-1:0]       in_site_a,
	input  logic [SITE_AW-1:0]       in_site_b,
	input  logic signed [31:0]       in_delta_x,
	input  logic signed [31:0]       in_delta_y,
	input  logic signed [31:0]       in_delta_z,
	input  logic [TAB_AW-1:0]        in_entry_index,
	input  logic signed [31:0]       in_entry_value,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               out_status,
	output logic signed [ACC_W-1:0]  out_force_x,
	output logic signed [ACC_W-1:0]  out_force_y,
	output logic signed [ACC_W-1:0]  out_force_z
);

	localparam logic [2:0] R_INTERP = 3'd0;
	localparam logic [2:0] R_PERIOD = 3'd1;
	localparam logic [2:0] R_RMODE  = 3'd2;
	localparam logic [2:0] R_BOX    = 3'd3;
	localparam logic [2:0] R_START  = 3'd4;
	localparam logic [2:0] R_INV    = 3'd5;
	localparam logic [2:0] R_POINTS = 3'd6;
	localparam logic [2:0] R_CUTOFF = 3'd7;
	localparam logic [PTS_W-1:0] PTS_MAX = PTS_W'(TABLE_DEPTH);
	localparam logic [PTS_W-1:0] PTS_MIN = PTS_W'(2);

	// configuration
	logic             interp_q, period_q, rmode_q;
	logic [30:0]      box_q, start_q, cutoff_q;
	logic [31:0]      inv_q;
	logic [PTS_W-1:0] points_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q <= 1'b1;
			period_q <= 1'b0;
			rmode_q  <= 1'b0;
			box_q    <= 31'd65536;
			start_q  <= '0;
			inv_q    <= 32'd65536;
			points_q <= PTS_W'(1024);
			cutoff_q <= 31'h7FFFFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				R_INTERP: interp_q <= cfg_data[0];
				R_PERIOD: period_q <= cfg_data[0];
				R_RMODE:  rmode_q  <= cfg_data[0];
				R_BOX:    box_q    <= cfg_data[30:0];
				R_START:  start_q  <= cfg_data[30:0];
				R_INV:    inv_q    <= cfg_data;
				R_POINTS: points_q <= cfg_data[PTS_W-1:0];
				R_CUTOFF: cutoff_q <= cfg_data[30:0];
				default:  ;
			endcase
		end
	end

	logic [PTS_W-1:0] pts;
	always_comb begin
		if (points_q < PTS_MIN)      pts = PTS_MIN;
		else if (points_q > PTS_MAX) pts = PTS_MAX;
		else                         pts = points_q;
	end

	// item registers
	logic                 wr_q;
	logic [1:0]           status_q;
	logic [SITE_AW-1:0]   sa_q, sb_q;
	logic signed [31:0]   d_q [3];
	logic [TAB_AW-1:0]    ei_q;
	logic signed [31:0]   ev_q;

	// arithmetic registers
	logic signed [63:0]   mul_q;
	logic [63:0]          r2_q;
	logic [63:0]          sv_q, sres_q, sbit_q;
	logic [63:0]          ph_q;
	logic [50:0]          p_q;
	logic                 tneg_q;
	logic                 noupd_q;
	logic [TAB_AW-1:0]    c_q;
	logic [16:0]          fr_q;
	logic signed [31:0]   trd_q, f0_q, f_q;
	logic [33:0]          mn_q [3];
	logic [31:0]          mr_q [3];
	logic                 mneg_q [3];
	logic                 gneg_q [3];
	logic [31:0]          grem_q [3];
	logic [31:0]          gq_q [3];

	logic [31:0] r;
	assign r = sres_q[31:0];

	logic [31:0] den;
	assign den = {box_q, 1'b0};

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic signed [33:0] tdiff;
	logic signed [32:0] fdiff;

	assign tdiff = $signed({2'b00, r}) - $signed({3'b000, start_q});
	assign fdiff = $signed({trd_q[31], trd_q}) - $signed({f0_q[31], f0_q});

	always_comb begin
		mul_a = {{2{d_q[cmd.mul_lane][31]}}, d_q[cmd.mul_lane]};
		mul_b = {{2{d_q[cmd.mul_lane][31]}}, d_q[cmd.mul_lane]};
		if (cmd.pos_hi) begin
			mul_a = tdiff;
			mul_b = {18'd0, inv_q[31:16]};
		end else if (cmd.pos_lo) begin
			mul_a = tdiff;
			mul_b = {18'd0, inv_q[15:0]};
		end else if (cmd.imul) begin
			mul_a = {fdiff[32], fdiff};
			mul_b = {17'd0, fr_q};
		end else if (cmd.g_mul) begin
			mul_a = {{2{f_q[31]}}, f_q};
		end
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		mul_q <= mul_p[63:0];
	end

	// item capture, squares, root, position, selection, table force value
	logic [64:0]        sq_sum;
	logic [50:0]        p_sum;
	logic [26:0]        last, pc, frw;
	logic               skip, err;
	logic [PTS_W-1:0]   ci, pm2, cc, cn;
	logic signed [33:0] fsum;

	assign sq_sum = {1'b0, sres_q} + {1'b0, sbit_q};
	assign p_sum  = {1'b0, ph_q[49:0]} + {17'd0, mul_q[49:16]};
	assign last   = {pts - PTS_W'(1), 16'd0};
	assign skip   = {1'b0, r} >= {2'b00, cutoff_q};
	assign err    = rmode_q && (tneg_q || p_q > {24'd0, last});
	assign pc     = (p_q > {24'd0, last}) ? last : p_q[26:0];
	assign ci     = pc[26:16];
	assign pm2    = pts - PTS_W'(2);
	assign cc     = (ci > pm2) ? pm2 : ci;
	assign frw    = pc - {cc, 16'd0};
	assign cn     = (pc[15:0] > HALF_Q16 && (ci + PTS_W'(1)) < pts) ? ci + PTS_W'(1) : ci;
	assign fsum   = $signed({{2{f0_q[31]}}, f0_q}) + $signed({mul_q[48], mul_q[48:16]});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sa_q    <= in_site_a;
			sb_q    <= in_site_b;
			ei_q    <= in_entry_index;
			ev_q    <= in_entry_value;
			wr_q    <= (in_action == ACT_WRITE);
			status_q <= (in_action == ACT_READ) ? ST_READ : ST_DONE;
			r2_q    <= '0;
		end
		if (cmd.sq_acc) r2_q <= r2_q + mul_q;
		if (cmd.sqrt_init) begin
			sv_q   <= r2_q;
			sres_q <= '0;
			sbit_q <= 64'h4000000000000000;
		end else if (cmd.sqrt_step) begin
			if ({1'b0, sv_q} >= sq_sum) begin
				sv_q   <= sv_q - sq_sum[63:0];
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
		if (cmd.pos_lo) ph_q <= mul_q;
		if (cmd.pos_calc) begin
			tneg_q <= tdiff[33];
			p_q    <= (tdiff[33] || tdiff == '0) ? '0 : p_sum;
		end
		if (cmd.sel_calc) begin
			noupd_q <= skip || err || (r == '0);
			if (skip)     status_q <= rmode_q ? ST_ERR : ST_SKIP;
			else if (err) status_q <= ST_ERR;
			else          status_q <= ST_DONE;
			c_q  <= interp_q ? cc[TAB_AW-1:0] : cn[TAB_AW-1:0];
			fr_q <= frw[16:0];
		end
		if (cmd.f0_cap) f0_q <= trd_q;
		if (cmd.fcalc)  f_q  <= interp_q ? fsum[31:0] : f0_q;
	end

	// minimum image and force division lanes
	logic signed [33:0] mim_n [3];
	logic [32:0]        mim_t [3];
	logic [31:0]        mim_r0 [3];
	logic signed [33:0] mim_dd [3];
	logic [63:0]        gmag;
	logic [32:0]        gdiv_t [3];

	assign gmag = mul_q[63] ? 64'(-mul_q) : 64'(mul_q);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mim_n[k]  = $signed({d_q[k][31], d_q[k], 1'b0}) + $signed({3'b000, box_q});
			mim_t[k]  = {mr_q[k], mn_q[k][33]};
			mim_r0[k] = (mneg_q[k] && mr_q[k] != '0) ? den - mr_q[k] : mr_q[k];
			mim_dd[k] = $signed({2'b00, mim_r0[k]}) - $signed({3'b000, box_q});
			gdiv_t[k] = {grem_q[k], gq_q[k][31]};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.mim_init) begin
				mneg_q[k] <= mim_n[k][33];
				mn_q[k]   <= mim_n[k][33] ? 34'(-mim_n[k]) : 34'(mim_n[k]);
				mr_q[k]   <= '0;
			end else if (cmd.mim_step) begin
				mn_q[k] <= {mn_q[k][32:0], 1'b0};
				mr_q[k] <= (mim_t[k] >= {1'b0, den}) ? 32'(mim_t[k] - {1'b0, den})
				                                     : mim_t[k][31:0];
			end
			if (cmd.g_cap && cmd.acc_lane == 2'(k)) begin
				gneg_q[k] <= mul_q[63];
				grem_q[k] <= gmag[63:32];
				gq_q[k]   <= gmag[31:0];
			end else if (cmd.gdiv_step) begin
				if (gdiv_t[k] >= {1'b0, r}) begin
					grem_q[k] <= 32'(gdiv_t[k] - {1'b0, r});
					gq_q[k]   <= {gq_q[k][30:0], 1'b1};
				end else begin
					grem_q[k] <= gdiv_t[k][31:0];
					gq_q[k]   <= {gq_q[k][30:0], 1'b0};
				end
			end
		end
		if (cmd.load) begin
			d_q[0] <= in_delta_x;
			d_q[1] <= in_delta_y;
			d_q[2] <= in_delta_z;
		end else if (cmd.mim_fin) begin
			for (int k = 0; k < 3; k++) d_q[k] <= mim_dd[k][32:1];
		end
	end

	// force table
	logic signed [31:0] tab_mem [TABLE_DEPTH];
	logic [TAB_AW-1:0]  tab_addr;

	assign tab_addr = cmd.tab_rd_next ? c_q + TAB_AW'(1) : c_q;

	always_ff @(posedge clk) begin
		if (cmd.tab_we) tab_mem[ei_q] <= ev_q;
		if (cmd.tab_rd || cmd.tab_rd_next) trd_q <= tab_mem[tab_addr];
	end

	// site accumulators
	logic [3*ACC_W-1:0] site_mem [SITE_COUNT];
	logic               svld_q [SITE_COUNT];
	logic [3*ACC_W-1:0] srd_q;
	logic               svr_q;
	logic [SITE_AW-1:0] saddr;
	logic [3*ACC_W-1:0] sdat, swdat;
	logic signed [32:0] g [3];
	logic signed [ACC_W:0] ssum [3];
	logic               site_we;

	assign saddr   = cmd.site_b ? sb_q : sa_q;
	assign sdat    = svr_q ? srd_q : '0;
	assign site_we = cmd.site_add || cmd.site_sub || cmd.clr_we;

	always_comb begin
		swdat = '0;
		for (int k = 0; k < 3; k++) begin
			g[k] = gneg_q[k] ? -$signed({1'b0, gq_q[k]}) : $signed({1'b0, gq_q[k]});
			if (cmd.site_sub)
				ssum[k] = $signed({sdat[k*ACC_W+ACC_W-1], sdat[k*ACC_W +: ACC_W]})
				        - $signed({{(ACC_W-32){g[k][32]}}, g[k]});
			else
				ssum[k] = $signed({sdat[k*ACC_W+ACC_W-1], sdat[k*ACC_W +: ACC_W]})
				        + $signed({{(ACC_W-32){g[k][32]}}, g[k]});
			if (!cmd.clr_we) begin
				if (ssum[k][ACC_W] != ssum[k][ACC_W-1])
					swdat[k*ACC_W +: ACC_W] = ssum[k][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
					                                         : {1'b0, {(ACC_W-1){1'b1}}};
				else
					swdat[k*ACC_W +: ACC_W] = ssum[k][ACC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (site_we) site_mem[saddr] <= swdat;
		if (cmd.site_rd) srd_q <= site_mem[saddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SITE_COUNT; i++) svld_q[i] <= 1'b0;
			svr_q <= 1'b0;
		end else begin
			if (site_we) svld_q[saddr] <= 1'b1;
			if (cmd.site_rd) svr_q <= svld_q[saddr];
		end
	end

	// output register
	logic                    ovld_q;
	logic [1:0]              ost_q;
	logic [3*ACC_W-1:0]      of_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovld_q <= 1'b1;
		end else if (out_ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ost_q <= status_q;
			of_q  <= wr_q ? '0 : sdat;
		end
	end

	assign out_valid    = ovld_q;
	assign out_status   = ost_q;
	assign out_force_x  = of_q[ACC_W-1:0];
	assign out_force_y  = of_q[2*ACC_W-1:ACC_W];
	assign out_force_z  = of_q[3*ACC_W-1:2*ACC_W];

	assign sts.mim_on   = period_q && (box_q != '0);
	assign sts.interp   = interp_q;
	assign sts.noupd    = noupd_q;
	assign sts.out_free = !ovld_q || out_ready;

endmodule

// ===== rtl/core/tabulated_pair_force_accumulator.sv =====
// top level of the tabulated pair force accumulator
//
// one input beat carries an action in s_axis_tuser and its operands in
// s_axis_tdata; every accepted beat gives exactly one result beat on m_axis
// with a status code in m_axis_tuser and the three accumulated force
// components of site_a in m_axis_tdata (zero for a table write)
// configuration registers are to be written through cfg_we, cfg_index, cfg_data
// only while no item is in flight; the block itself does not enforce this
// one item is worked on at a time: s_axis_tready is high only when the
// sequencer is idle
// table write or clear: the write, then a read of site_a; read: that read alone
// pair evaluation: the 34-step box remainder when the minimum image is on, the
// squares, the 32-step square root, the position, the table reads, an interpolation
// multiply only with interpolation, the 32-step force divider and the accumulator
// read-modify-write; a pair that is skipped, flagged or at zero distance goes from
// the first table read straight to the read of site_a for the result
// the result sits in an output register, so a stalled receiver holds it there
// and the block stops only when a second result is ready to be loaded
// reset clears the configuration to its defaults and all accumulators to zero
// through per-site valid bits, with no sweep; the table is undefined until written
module tabulated_pair_force_accumulator import tpfa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// site_a, site_b, delta_x, delta_y, delta_z, entry_index, entry_value, zero fill
	input  logic [159:0] s_axis_tdata,
	// action
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// force_x, force_y, force_z
	output logic [143:0] m_axis_tdata,
	// status
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic signed [ACC_W-1:0] fx, fy, fz;

	tpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpfa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_action      (s_axis_tuser),
		.in_site_a      (s_axis_tdata[7:0]),
		.in_site_b      (s_axis_tdata[15:8]),
		.in_delta_x     (s_axis_tdata[47:16]),
		.in_delta_y     (s_axis_tdata[79:48]),
		.in_delta_z     (s_axis_tdata[111:80]),
		.in_entry_index (s_axis_tdata[121:112]),
		.in_entry_value (s_axis_tdata[153:122]),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_status     (m_axis_tuser),
		.out_force_x    (fx),
		.out_force_y    (fy),
		.out_force_z    (fz)
	);

	assign m_axis_tdata = {fz, fy, fx};

endmodule

// ===== rtl/core/tpfa_chk.sv =====
// port-level checks of the tabulated pair force accumulator
module tpfa_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// a new result only after the block has been busy
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared from an idle block");

endmodule

bind tabulated_pair_force_accumulator tpfa_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
